[src/mbe_pkg.sv]
package mbe_pkg;

  // Frame size seen by the coordinate mapping
  localparam int unsigned WIDTH  = 1024;
  localparam int unsigned HEIGHT = 1024;

  localparam int unsigned NUM_W  = 14;   // p - mouse - size/2
  localparam int unsigned DEN_W  = 46;   // zoom*size + mouse<<24, Q.24
  localparam int unsigned DIVD_W = 64;   // dividend of both dividers
  localparam int unsigned CNT_W  = 7;

  localparam logic signed [NUM_W-1:0] HALF_W = NUM_W'(WIDTH / 2);
  localparam logic signed [NUM_W-1:0] HALF_H = NUM_W'(HEIGHT / 2);

  localparam logic [CNT_W-1:0] AXIS_STEPS = CNT_W'(64);
  localparam logic [CNT_W-1:0] COL_STEPS  = CNT_W'(20);

  localparam logic [19:0] COLOUR_BASE = 20'h0F0000;
  localparam logic [63:0] FOUR_Q56    = 64'h0400_0000_0000_0000;

  // Configuration register indexes
  localparam logic [2:0] CFG_MOUSE_X = 3'd0;
  localparam logic [2:0] CFG_MOUSE_Y = 3'd1;
  localparam logic [2:0] CFG_ZOOM    = 3'd2;
  localparam logic [2:0] CFG_SHIFT_R = 3'd3;
  localparam logic [2:0] CFG_SHIFT_I = 3'd4;
  localparam logic [2:0] CFG_LIMIT   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_MUL,
    ST_UPD,
    ST_COL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic set_c;
    logic mul;
    logic upd;
    logic col_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic lim_hit;
    logic escaped;
  } status_t;

endpackage

[src/mandelbrot_escape_time_pixel_top.sv]
// Mandelbrot escape-time evaluator, one pixel per item.
// Input channel: in_valid/in_ready with in_pixel_x, in_pixel_y. The block
// maps the pixel to c, iterates z = z*z + c and returns one result item.
// Result channel: out_valid/out_ready with out_x, out_y, out_iterations,
// out_draw and out_colour, held in an output register.
// Configuration: cfg_we/cfg_index/cfg_data write mouse_x, mouse_y,
// zoom_factor, shift_real, shift_imag and iteration_limit; write while idle.
// Sequence from the accepting edge to out_valid: a start state, the
// bit-serial coordinate dividers (both axes in parallel), loading c, the
// iterations (multiply, then escape test and update), a final test, a
// colour start, the colour divide on the shared x divider, and loading the
// result.
// Throughput: one item at a time; in_ready is high only between items.
// A finished item waits in the output register while the next is taken in;
// if the receiver stalls, the next result waits until that register frees.
// Reset (synchronous, rst_n low) restores the default configuration
// and drops any item in flight and any pending result.
module mandelbrot_escape_time_pixel_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  in_pixel_x,
  input  logic [9:0]  in_pixel_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_x,
  output logic [9:0]  out_y,
  output logic [11:0] out_iterations,
  output logic        out_draw,
  output logic [19:0] out_colour
);

  mbe_pkg::cmd_t    cmd;
  mbe_pkg::status_t st;

  mbe_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .st(st), .cmd(cmd)
  );

  mbe_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y),
    .cmd(cmd), .st(st), .out_x(out_x), .out_y(out_y),
    .out_iterations(out_iterations), .out_draw(out_draw), .out_colour(out_colour)
  );

endmodule

[src/mbe_div.sv]
module mbe_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mbe_pkg::DIVD_W-1:0]  dividend,
  input  logic [mbe_pkg::DEN_W-1:0]   divisor,
  input  logic [mbe_pkg::CNT_W-1:0]   steps,
  output logic                        busy,
  output logic [32:0]                 quo,
  output logic                        ovf
);

  logic                       busy_r, busy_nxt;
  logic [mbe_pkg::CNT_W-1:0]  cnt_r;
  logic [mbe_pkg::DIVD_W-1:0] d_r;
  logic [mbe_pkg::DEN_W-1:0]  den_r;
  logic [mbe_pkg::DEN_W-1:0]  rem_r, rem_nxt;
  logic [32:0]                q_r;
  logic                       ovf_r;
  logic [mbe_pkg::DEN_W:0]    rem_sh;
  logic                       qbit;

  // One restoring step: bring down the next dividend bit
  always_comb begin
    rem_sh  = {rem_r, d_r[mbe_pkg::DIVD_W-1]};
    qbit    = (rem_sh >= {1'b0, den_r});
    rem_nxt = qbit ? mbe_pkg::DEN_W'(rem_sh - {1'b0, den_r})
                   : rem_sh[mbe_pkg::DEN_W-1:0];
    busy_nxt = busy_r;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == mbe_pkg::CNT_W'(1)) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // Load operands or advance one quotient bit
  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= dividend;
      den_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
      cnt_r <= steps;
    end else if (busy_r) begin
      d_r   <= {d_r[mbe_pkg::DIVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= {q_r[31:0], qbit};
      ovf_r <= ovf_r | q_r[32];
      cnt_r <= cnt_r - mbe_pkg::CNT_W'(1);
    end
  end

  assign busy = busy_r;
  assign quo  = q_r;
  assign ovf  = ovf_r;

endmodule

[src/mbe_dp.sv]
module mbe_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [9:0]           in_pixel_x,
  input  logic [9:0]           in_pixel_y,
  input  mbe_pkg::cmd_t        cmd,
  output mbe_pkg::status_t     st,
  output logic [9:0]           out_x,
  output logic [9:0]           out_y,
  output logic [11:0]          out_iterations,
  output logic                 out_draw,
  output logic [19:0]          out_colour
);

  logic [10:0]        mouse_x_r, mouse_y_r;
  logic [31:0]        zoom_r;
  logic signed [31:0] shift_r_r, shift_i_r;
  logic [11:0]        limit_r;

  logic [9:0]         px_r, py_r;
  logic signed [mbe_pkg::NUM_W-1:0] numx_r, numy_r;
  logic signed [mbe_pkg::NUM_W-1:0] numx, numy;
  logic [mbe_pkg::NUM_W-1:0] magx, magy;
  logic signed [31:0] cr_r, ci_r, zr_r, zi_r;
  logic signed [63:0] prr_r, pii_r, pri_r;
  logic [11:0]        i_r;

  logic                       divx_start, divy_start, busy_x, busy_y, ovf_x, ovf_y;
  logic [mbe_pkg::DIVD_W-1:0] divx_dvd, divy_dvd;
  logic [mbe_pkg::DEN_W-1:0]  divx_den, divy_den;
  logic [mbe_pkg::CNT_W-1:0]  divx_steps;
  logic [32:0]                quo_x, quo_y;
  logic [19:0]                i255;
  logic [63:0]                mag_sum;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Apply sign, zero numerator and range limits, then add the shift
  function automatic logic signed [31:0] map_fin(
    input logic signed [mbe_pkg::NUM_W-1:0] num,
    input logic [32:0] q,
    input logic ovf,
    input logic signed [31:0] shift
  );
    logic signed [33:0] qs;
    logic               big;
    qs  = '0;
    big = 1'b0;
    if (num == '0) begin
      qs = '0;
    end else if (!num[mbe_pkg::NUM_W-1]) begin
      big = ovf | q[32] | q[31];
      qs  = big ? 34'sh0_7FFF_FFFF : $signed({1'b0, q});
    end else begin
      big = ovf | q[32] | (q[31] & (|q[30:0]));
      qs  = big ? -34'sh0_8000_0000 : -$signed({1'b0, q});
    end
    return sat32(64'(qs) + 64'(shift));
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mouse_x_r <= 11'd700;
      mouse_y_r <= 11'd500;
      zoom_r    <= 32'h0100_0000;
      shift_r_r <= -32'sh0800_0000;
      shift_i_r <= '0;
      limit_r   <= 12'd150;
    end else if (cfg_we) begin
      case (cfg_index)
        mbe_pkg::CFG_MOUSE_X: mouse_x_r <= cfg_data[10:0];
        mbe_pkg::CFG_MOUSE_Y: mouse_y_r <= cfg_data[10:0];
        mbe_pkg::CFG_ZOOM:    zoom_r    <= cfg_data;
        mbe_pkg::CFG_SHIFT_R: shift_r_r <= $signed(cfg_data);
        mbe_pkg::CFG_SHIFT_I: shift_i_r <= $signed(cfg_data);
        mbe_pkg::CFG_LIMIT:   limit_r   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Numerators and divider operands
  always_comb begin
    numx = $signed({4'b0, px_r}) - $signed({3'b0, mouse_x_r}) - mbe_pkg::HALF_W;
    numy = $signed({4'b0, py_r}) - $signed({3'b0, mouse_y_r}) - mbe_pkg::HALF_H;
    magx = numx[mbe_pkg::NUM_W-1] ? mbe_pkg::NUM_W'(-numx) : mbe_pkg::NUM_W'(numx);
    magy = numy[mbe_pkg::NUM_W-1] ? mbe_pkg::NUM_W'(-numy) : mbe_pkg::NUM_W'(numy);
    i255 = (20'(i_r) << 8) - 20'(i_r);
    divx_start = cmd.div_start | cmd.col_start;
    divy_start = cmd.div_start;
    if (cmd.col_start) begin
      divx_dvd   = {i255, 44'b0};
      divx_den   = mbe_pkg::DEN_W'(limit_r);
      divx_steps = mbe_pkg::COL_STEPS;
    end else begin
      divx_dvd   = {magx[11:0], 52'b0};
      divx_den   = mbe_pkg::DEN_W'(zoom_r) * mbe_pkg::DEN_W'(mbe_pkg::WIDTH)
                 + (mbe_pkg::DEN_W'(mouse_x_r) << 24);
      divx_steps = mbe_pkg::AXIS_STEPS;
    end
    divy_dvd = {magy[11:0], 52'b0};
    divy_den = mbe_pkg::DEN_W'(zoom_r) * mbe_pkg::DEN_W'(mbe_pkg::HEIGHT)
             + (mbe_pkg::DEN_W'(mouse_y_r) << 24);
    mag_sum = 64'(prr_r) + 64'(pii_r);
  end

  mbe_div u_div_x (
    .clk(clk), .rst_n(rst_n), .start(divx_start), .dividend(divx_dvd),
    .divisor(divx_den), .steps(divx_steps), .busy(busy_x), .quo(quo_x), .ovf(ovf_x)
  );

  mbe_div u_div_y (
    .clk(clk), .rst_n(rst_n), .start(divy_start), .dividend(divy_dvd),
    .divisor(divy_den), .steps(mbe_pkg::AXIS_STEPS), .busy(busy_y), .quo(quo_y),
    .ovf(ovf_y)
  );

  // Pixel capture, point mapping and iteration
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= in_pixel_x;
      py_r <= in_pixel_y;
    end
    if (cmd.div_start) begin
      numx_r <= numx;
      numy_r <= numy;
    end
    if (cmd.set_c) begin
      cr_r <= map_fin(numx_r, quo_x, ovf_x, shift_r_r);
      ci_r <= map_fin(numy_r, quo_y, ovf_y, shift_i_r);
      zr_r <= '0;
      zi_r <= '0;
      i_r  <= '0;
    end
    if (cmd.mul) begin
      prr_r <= zr_r * zr_r;
      pii_r <= zi_r * zi_r;
      pri_r <= zr_r * zi_r;
    end
    if (cmd.upd) begin
      zi_r <= sat32((pri_r >>> 27) + 64'(ci_r));
      zr_r <= sat32(((prr_r - pii_r) >>> 28) + 64'(cr_r));
      i_r  <= i_r + 12'd1;
    end
    if (cmd.out_load) begin
      out_x          <= px_r;
      out_y          <= py_r;
      out_iterations <= i_r;
      out_draw       <= (i_r != limit_r);
      out_colour     <= (limit_r == '0) ? mbe_pkg::COLOUR_BASE
                      : mbe_pkg::COLOUR_BASE + {12'b0, quo_x[7:0]};
    end
  end

  assign st.div_busy = busy_x | busy_y;
  assign st.lim_hit  = (i_r == limit_r);
  assign st.escaped  = (mag_sum >= mbe_pkg::FOUR_Q56);

endmodule

[src/mbe_ctrl.sv]
module mbe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mbe_pkg::status_t  st,
  output mbe_pkg::cmd_t     cmd
);

  mbe_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbe_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sequence divide, iterate, colour divide, then hand off the item
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    case (state_r)
      mbe_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = mbe_pkg::ST_START;
        end
      end
      mbe_pkg::ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = mbe_pkg::ST_DIV;
      end
      mbe_pkg::ST_DIV: begin
        if (!st.div_busy) begin
          cmd.set_c = 1'b1;
          state_nxt = mbe_pkg::ST_MUL;
        end
      end
      mbe_pkg::ST_MUL: begin
        if (st.lim_hit) begin
          state_nxt = mbe_pkg::ST_COL;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = mbe_pkg::ST_UPD;
        end
      end
      mbe_pkg::ST_UPD: begin
        if (st.escaped) begin
          state_nxt = mbe_pkg::ST_COL;
        end else begin
          cmd.upd   = 1'b1;
          state_nxt = mbe_pkg::ST_MUL;
        end
      end
      mbe_pkg::ST_COL: begin
        cmd.col_start = 1'b1;
        state_nxt     = mbe_pkg::ST_OUT;
      end
      mbe_pkg::ST_OUT: begin
        if (!st.div_busy && (!out_valid_r || out_ready)) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = mbe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mbe_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> st.div_busy) else $error("divider did not start");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready)) else $error("result overwritten");
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |-> !st.lim_hit) else $error("iteration past limit");

endmodule

[verif/mandelbrot_escape_time_pixel_top_tb.sv]
`timescale 1ns / 100ps

module mandelbrot_escape_time_pixel_top_tb;

  typedef struct {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [11:0] iters;
    logic        draw;
    logic [19:0] colour;
  } pixel_res_t;

  typedef struct {
    logic [9:0]  x;
    logic [9:0]  y;
    logic        typed;
    logic [11:0] iters;
    logic        draw;
    logic [19:0] colour;
  } pixel_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [9:0]  in_pixel_x = '0;
  logic [9:0]  in_pixel_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  out_x;
  logic [9:0]  out_y;
  logic [11:0] out_iterations;
  logic        out_draw;
  logic [19:0] out_colour;

  // Shadow copy of the configuration
  logic [10:0]        m_mouse_x, m_mouse_y;
  logic [31:0]        m_zoom;
  logic signed [31:0] m_shift_r, m_shift_i;
  logic [11:0]        m_limit;

  pixel_res_t pending_pixels[$];
  int  errors = 0;
  int  send_idle = 14;
  int  recv_idle = 56;

  mandelbrot_escape_time_pixel_top DUT (.*);

  always #5 clk = ~clk;

  function automatic longint sat28(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Map one axis from pixel to Q4.28 coordinate
  function automatic longint axis_coord(longint p, longint mouse, longint size,
                                        longint shift);
    longint num, q;
    logic [63:0] den, mag, u;
    logic [127:0] wide;
    num = p - mouse - size / 2;
    den = 64'(m_zoom) * 64'(size) + (64'(mouse) << 24);
    mag = (num < 0) ? -num : num;
    if (num == 0) q = 0;
    else if (den == 0) q = (num > 0) ? 64'sd2147483647 : -64'sd2147483648;
    else begin
      wide = {64'd0, mag} << 52;
      u = 64'(wide / {64'd0, den});
      if (num > 0) q = (u > 64'd2147483647) ? 64'sd2147483647 : longint'(u);
      else q = (u > 64'd2147483648) ? -64'sd2147483648 : -longint'(u);
    end
    return sat28(q + shift);
  endfunction

  function automatic pixel_res_t escape_pixel(logic [9:0] px, logic [9:0] py);
    pixel_res_t r;
    longint cr, ci, zr, zi, sr, si, nr, ni;
    int unsigned n;
    cr = axis_coord(px, m_mouse_x, mbe_pkg::WIDTH, m_shift_r);
    ci = axis_coord(py, m_mouse_y, mbe_pkg::HEIGHT, m_shift_i);
    zr = 0; zi = 0; n = 0;
    while (n < m_limit) begin
      sr = zr * zr;
      si = zi * zi;
      if (64'(sr) + 64'(si) >= mbe_pkg::FOUR_Q56) break;
      ni = sat28(((zr * zi) >>> 27) + ci);
      nr = sat28(((sr - si) >>> 28) + cr);
      zr = nr; zi = ni;
      n++;
    end
    r.x = px; r.y = py; r.iters = 12'(n);
    r.draw = (n != m_limit);
    r.colour = (m_limit == 0) ? mbe_pkg::COLOUR_BASE
             : 20'(mbe_pkg::COLOUR_BASE + (n * 255) / m_limit);
    return r;
  endfunction

  // Write one register, then drop the write enable
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mbe_pkg::CFG_MOUSE_X: m_mouse_x = val[10:0];
      mbe_pkg::CFG_MOUSE_Y: m_mouse_y = val[10:0];
      mbe_pkg::CFG_ZOOM:    m_zoom    = val;
      mbe_pkg::CFG_SHIFT_R: m_shift_r = val;
      mbe_pkg::CFG_SHIFT_I: m_shift_i = val;
      mbe_pkg::CFG_LIMIT:   m_limit   = val[11:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drain results, then let the block settle before a register write
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_pixel(logic [9:0] px, logic [9:0] py);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; in_pixel_x <= px; in_pixel_y <= py;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_pixels.push_back(escape_pixel(px, py));
  endtask

  // Receiver: randomly stall, check each accepted result
  always @(posedge clk) begin
    pixel_res_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          $error("unexpected result x=%0d y=%0d", out_x, out_y);
          errors++;
        end else begin
          e = pending_pixels.pop_front();
          if (out_x !== e.x) begin $error("out_x exp %0d got %0d", e.x, out_x); errors++; end
          if (out_y !== e.y) begin $error("out_y exp %0d got %0d", e.y, out_y); errors++; end
          if (out_iterations !== e.iters) begin
            $error("iterations exp %0d got %0d", e.iters, out_iterations); errors++;
          end
          if (out_draw !== e.draw) begin
            $error("draw exp %0d got %0d", e.draw, out_draw); errors++;
          end
          if (out_colour !== e.colour) begin
            $error("colour exp %h got %h", e.colour, out_colour); errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Directed rows; typed results at limit zero only
  pixel_row_t dir_rows[$];

  task automatic run_rows();
    pixel_res_t p;
    foreach (dir_rows[k]) begin
      send_pixel(dir_rows[k].x, dir_rows[k].y);
      if (dir_rows[k].typed) begin
        p.x = dir_rows[k].x; p.y = dir_rows[k].y; p.iters = dir_rows[k].iters;
        p.draw = dir_rows[k].draw; p.colour = dir_rows[k].colour;
        pending_pixels[pending_pixels.size()-1] = p;
      end
    end
  endtask

  task automatic random_cfg(int mode);
    write_reg(mbe_pkg::CFG_MOUSE_X, $urandom_range(1024));
    write_reg(mbe_pkg::CFG_MOUSE_Y, $urandom_range(1024));
    case (mode)
      0: write_reg(mbe_pkg::CFG_ZOOM, $urandom_range(32'h0200_0000, 32'h0040_0000));
      1: write_reg(mbe_pkg::CFG_ZOOM, $urandom);
      default: write_reg(mbe_pkg::CFG_ZOOM, 32'h0100_0000);
    endcase
    write_reg(mbe_pkg::CFG_SHIFT_R,
              $urandom_range(1) ? $urandom : 32'(-$urandom_range(32'h2000_0000)));
    write_reg(mbe_pkg::CFG_SHIFT_I,
              $urandom_range(1) ? $urandom : 32'($urandom_range(32'h1000_0000)));
    write_reg(mbe_pkg::CFG_LIMIT, $urandom_range(1, 60));
  endtask

  initial begin
    #100_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    m_mouse_x = 700; m_mouse_y = 500; m_zoom = 32'h0100_0000;
    m_shift_r = -32'sd134217728; m_shift_i = 0; m_limit = 150;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults after reset, pixel extremes
    dir_rows = '{
      '{0, 0, 0, 0, 0, 0}, '{1023, 1023, 0, 0, 0, 0}, '{0, 1023, 0, 0, 0, 0},
      '{1023, 0, 0, 0, 0, 0}, '{700+512-1024, 500, 0, 0, 0, 0},
      '{188, 12, 0, 0, 0, 0}, '{512, 512, 0, 0, 0, 0}, '{341, 682, 0, 0, 0, 0}};
    run_rows();
    wait_idle();

    // Zero limit: no step, base colour
    write_reg(mbe_pkg::CFG_LIMIT, 0);
    dir_rows = '{'{5, 9, 1, 0, 0, 20'h0F0000}, '{1023, 0, 1, 0, 0, 20'h0F0000}};
    run_rows();
    wait_idle();

    // Zero divisor saturation, shift extremes, max limit
    write_reg(mbe_pkg::CFG_MOUSE_X, 0); write_reg(mbe_pkg::CFG_MOUSE_Y, 0);
    write_reg(mbe_pkg::CFG_ZOOM, 0);
    write_reg(mbe_pkg::CFG_SHIFT_R, 32'h7FFF_FFFF);
    write_reg(mbe_pkg::CFG_SHIFT_I, 32'h8000_0000);
    write_reg(mbe_pkg::CFG_LIMIT, 4095);
    dir_rows = '{'{512, 512, 0, 0, 0, 0}, '{0, 1023, 0, 0, 0, 0}, '{1023, 0, 0, 0, 0, 0}};
    run_rows();
    wait_idle();
    write_reg(mbe_pkg::CFG_SHIFT_R, 0); write_reg(mbe_pkg::CFG_SHIFT_I, 0);
    write_reg(mbe_pkg::CFG_LIMIT, 1);
    dir_rows = '{'{512, 512, 0, 0, 0, 0}, '{3, 700, 0, 0, 0, 0}};
    run_rows();
    wait_idle();
    write_reg(mbe_pkg::CFG_MOUSE_X, 1024); write_reg(mbe_pkg::CFG_MOUSE_Y, 1024);
    write_reg(mbe_pkg::CFG_ZOOM, 32'hFFFF_FFFF); write_reg(mbe_pkg::CFG_LIMIT, 40);
    dir_rows = '{'{0, 0, 0, 0, 0, 0}, '{1023, 1023, 0, 0, 0, 0}};
    run_rows();
    wait_idle();

    // Random phases, changing idle profile
    for (int ph = 0; ph < 26; ph++) begin
      if (ph == 9) begin send_idle = 56; recv_idle = 14; end
      if (ph == 18) begin send_idle = 0; recv_idle = 0; end
      random_cfg(ph % 3);
      for (int k = 0; k < 25; k++) send_pixel(10'($urandom), 10'($urandom));
      wait_idle();
    end

    wait_idle();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[mandelbrot_escape_time_pixel_top.f]
src/mbe_pkg.sv
src/mbe_div.sv
src/mbe_dp.sv
src/mbe_ctrl.sv
src/mandelbrot_escape_time_pixel_top.sv
verif/mandelbrot_escape_time_pixel_top_tb.sv
